@@ src/vmrp_pkg.sv @@
// Shared types and constants for the video memory register port.
// Register offsets, read kinds and the stage record passed between modules.
// No dependencies.
package vmrp_pkg;

   // default memory sizes in bytes
   localparam int VIDEO_BYTES_DEF   = 65536;
   localparam int PALETTE_BYTES_DEF = 512;
   localparam int OBJECT_BYTES_DEF  = 544;

   // span of the 16-bit video address counter
   localparam int VID_SPAN = 65536;

   localparam int LAYER_COUNT  = 11;
   localparam int SCROLL_COUNT = 4;

   // bus operation codes
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // register offsets within the window
   localparam logic [5:0] REG_DISPLAY      = 6'h00;
   localparam logic [5:0] REG_OBJ_SIZE     = 6'h01;
   localparam logic [5:0] REG_OAM_ADDR_LO  = 6'h02;
   localparam logic [5:0] REG_OAM_ADDR_HI  = 6'h03;
   localparam logic [5:0] REG_OAM_DATA     = 6'h04;
   localparam logic [5:0] REG_BG_MODE      = 6'h05;
   localparam logic [5:0] REG_MOSAIC       = 6'h06;
   localparam logic [5:0] REG_BG1_MAP      = 6'h07;
   localparam logic [5:0] REG_BG2_MAP      = 6'h08;
   localparam logic [5:0] REG_BG3_MAP      = 6'h09;
   localparam logic [5:0] REG_BG4_MAP      = 6'h0A;
   localparam logic [5:0] REG_BG12_CHR     = 6'h0B;
   localparam logic [5:0] REG_BG34_CHR     = 6'h0C;
   localparam logic [5:0] REG_HSCROLL1     = 6'h0D;
   localparam logic [5:0] REG_HSCROLL2     = 6'h0E;
   localparam logic [5:0] REG_HSCROLL3     = 6'h0F;
   localparam logic [5:0] REG_HSCROLL4     = 6'h10;
   localparam logic [5:0] REG_VSCROLL1     = 6'h11;
   localparam logic [5:0] REG_VSCROLL2     = 6'h12;
   localparam logic [5:0] REG_VSCROLL3     = 6'h13;
   localparam logic [5:0] REG_VSCROLL4     = 6'h14;
   localparam logic [5:0] REG_VRAM_INC     = 6'h15;
   localparam logic [5:0] REG_VRAM_ADDR_LO = 6'h16;
   localparam logic [5:0] REG_VRAM_ADDR_HI = 6'h17;
   localparam logic [5:0] REG_VRAM_DATA_LO = 6'h18;
   localparam logic [5:0] REG_VRAM_DATA_HI = 6'h19;
   localparam logic [5:0] REG_CG_ADDR      = 6'h21;
   localparam logic [5:0] REG_CG_DATA      = 6'h22;
   localparam logic [5:0] REG_MAIN_SCREEN  = 6'h2C;
   localparam logic [5:0] REG_OAM_READ     = 6'h38;
   localparam logic [5:0] REG_VRAM_READ_LO = 6'h39;
   localparam logic [5:0] REG_VRAM_READ_HI = 6'h3A;
   localparam logic [5:0] REG_CG_READ      = 6'h3B;
   localparam logic [5:0] REG_STATUS0      = 6'h3C;
   localparam logic [5:0] REG_STATUS1      = 6'h3D;
   localparam logic [5:0] REG_STATUS2      = 6'h3E;
   localparam logic [5:0] REG_STATUS3      = 6'h3F;

   // what the response stage returns for an item
   typedef enum logic [2:0] {
      RD_NONE     = 3'd0,
      RD_OBJECT   = 3'd1,
      RD_VIDEO_LO = 3'd2,
      RD_VIDEO_HI = 3'd3,
      RD_PALETTE  = 3'd4,
      RD_STATUS   = 3'd5
   } read_kind_type;

   typedef struct packed {
      read_kind_type kind;
      logic          vblank;
      logic          hblank;
   } stage_type;

   // handshake status of the response stage
   typedef struct packed {
      logic s1_valid;
      logic s1_advance;
   } flow_type;

endpackage

@@ src/vmrp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vmrp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/vmrp_ctrl.sv @@
// Register decode, address counters, stored settings and the three memories.
// Runs the clearing sweep after reset. Uses vmrp_pkg and vmrp_ram.
module vmrp_ctrl #(
   parameter int VIDEO_BYTES   = vmrp_pkg::VIDEO_BYTES_DEF,
   parameter int PALETTE_BYTES = vmrp_pkg::PALETTE_BYTES_DEF,
   parameter int OBJECT_BYTES  = vmrp_pkg::OBJECT_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                req_operation,
   input  logic [5:0]          req_reg_index,
   input  logic [7:0]          req_write_data,
   input  logic                req_vblank_in,
   input  logic                req_hblank_in,
   output logic                clear_busy,
   output vmrp_pkg::stage_type stage,
   output logic [7:0]          video_rd_lo,
   output logic [7:0]          video_rd_hi,
   output logic [7:0]          palette_rd,
   output logic [7:0]          object_rd
);

   localparam int VA       = $clog2(VIDEO_BYTES);
   localparam int PA       = $clog2(PALETTE_BYTES);
   localparam int OA       = $clog2(OBJECT_BYTES);
   localparam int CW       = $clog2(VIDEO_BYTES + 1);
   localparam int VidSteps = $clog2(vmrp_pkg::VID_SPAN / VIDEO_BYTES) + 1;
   localparam int ModW     = 16 + VidSteps;

   // address mod VIDEO_BYTES by shifted compare-subtract steps
   function automatic logic [15:0] vid_mod(input logic [15:0] a);
      logic [ModW-1:0] r;
      r = ModW'(a);
      for (int k = VidSteps - 1; k >= 0; k--) begin
         if (r >= (ModW'(VIDEO_BYTES) << k)) begin
            r = r - (ModW'(VIDEO_BYTES) << k);
         end
      end
      return r[15:0];
   endfunction

   // architectural state
   logic [15:0] video_address_ff, video_address_in;
   logic [7:0]  increment_mode_ff, increment_mode_in;
   logic [8:0]  palette_address_ff, palette_address_in;
   logic [8:0]  object_address_ff, object_address_in;
   logic        object_low_phase_ff, object_low_phase_in;
   logic [1:0]  object_rotation_ff, object_rotation_in;
   logic [8:0]  hscroll_ff [vmrp_pkg::SCROLL_COUNT];
   logic [8:0]  hscroll_in [vmrp_pkg::SCROLL_COUNT];
   logic [7:0]  scroll_low_ff [vmrp_pkg::SCROLL_COUNT];
   logic [7:0]  scroll_low_in [vmrp_pkg::SCROLL_COUNT];
   logic        scroll_first_ff [vmrp_pkg::SCROLL_COUNT];
   logic        scroll_first_in [vmrp_pkg::SCROLL_COUNT];
   logic [7:0]  vscroll_ff [vmrp_pkg::SCROLL_COUNT];
   logic [7:0]  vscroll_in [vmrp_pkg::SCROLL_COUNT];
   logic [7:0]  layer_ff [vmrp_pkg::LAYER_COUNT];
   logic [7:0]  layer_in [vmrp_pkg::LAYER_COUNT];

   // clearing sweep
   logic          clear_busy_ff, clear_busy_in;
   logic [CW-1:0] clear_count_ff, clear_count_in;

   // item record for the response stage
   vmrp_pkg::stage_type stage_ff, stage_in;

   // derived addresses
   logic [15:0]   vid_inc;
   logic [15:0]   vid_mod0, vid_mod1;
   logic [VA-1:0] vid_idx0, vid_idx1;
   logic [PA-1:0] pal_idx;
   logic [OA-1:0] obj_idx;
   logic [1:0]    scroll_sel;

   // memory access strobes from decode
   logic vid_wr, pal_wr, obj_wr;
   logic vid_rd, pal_rd, obj_rd;

   // memory ports after the clearing mux
   logic          vid_we, pal_we, obj_we;
   logic [VA-1:0] vid_wa;
   logic [PA-1:0] pal_wa;
   logic [OA-1:0] obj_wa;
   logic [7:0]    wdata;

   assign vid_inc  = increment_mode_ff[7] ? (16'd1 << increment_mode_ff[6:4]) : 16'd1;
   assign vid_mod0 = vid_mod(video_address_ff);
   assign vid_mod1 = vid_mod(video_address_ff + 16'd1);
   assign vid_idx0 = vid_mod0[VA-1:0];
   assign vid_idx1 = vid_mod1[VA-1:0];
   assign pal_idx  = palette_address_ff[PA-1:0];
   // the 9-bit address plus one stays below OBJECT_BYTES, so no wrap is needed
   assign obj_idx  = OA'(object_address_ff) + (object_low_phase_ff ? OA'(0) : OA'(1));
   // scroll registers come in groups of four starting at offsets ending in 01
   assign scroll_sel = req_reg_index[1:0] - 2'b01;

   always_comb begin
      video_address_in    = video_address_ff;
      increment_mode_in   = increment_mode_ff;
      palette_address_in  = palette_address_ff;
      object_address_in   = object_address_ff;
      object_low_phase_in = object_low_phase_ff;
      object_rotation_in  = object_rotation_ff;
      hscroll_in          = hscroll_ff;
      scroll_low_in       = scroll_low_ff;
      scroll_first_in     = scroll_first_ff;
      vscroll_in          = vscroll_ff;
      layer_in            = layer_ff;
      stage_in.kind       = vmrp_pkg::RD_NONE;
      stage_in.vblank     = req_vblank_in;
      stage_in.hblank     = req_hblank_in;
      vid_wr = 1'b0;
      pal_wr = 1'b0;
      obj_wr = 1'b0;
      vid_rd = 1'b0;
      pal_rd = 1'b0;
      obj_rd = 1'b0;
      if (accept && req_operation == vmrp_pkg::OP_WRITE) begin
         case (req_reg_index)
            vmrp_pkg::REG_DISPLAY:     layer_in[0] = req_write_data;
            vmrp_pkg::REG_OBJ_SIZE:    layer_in[1] = req_write_data;
            vmrp_pkg::REG_OAM_ADDR_LO: begin
               object_address_in   = {object_address_ff[8], req_write_data};
               object_rotation_in  = {req_write_data[7], req_write_data[0]};
               object_low_phase_in = 1'b1;
            end
            vmrp_pkg::REG_OAM_ADDR_HI: begin
               object_address_in   = {req_write_data[0], object_address_ff[7:0]};
               object_low_phase_in = 1'b1;
            end
            vmrp_pkg::REG_OAM_DATA: begin
               obj_wr = 1'b1;
               if (!object_low_phase_ff) begin
                  object_address_in = object_address_ff + 9'd2;
               end
               object_low_phase_in = ~object_low_phase_ff;
            end
            vmrp_pkg::REG_BG_MODE:     layer_in[2] = req_write_data;
            vmrp_pkg::REG_MOSAIC:      layer_in[3] = req_write_data;
            vmrp_pkg::REG_BG1_MAP:     layer_in[4] = req_write_data;
            vmrp_pkg::REG_BG2_MAP:     layer_in[5] = req_write_data;
            vmrp_pkg::REG_BG3_MAP:     layer_in[6] = req_write_data;
            vmrp_pkg::REG_BG4_MAP:     layer_in[7] = req_write_data;
            vmrp_pkg::REG_BG12_CHR:    layer_in[8] = req_write_data;
            vmrp_pkg::REG_BG34_CHR:    layer_in[9] = req_write_data;
            vmrp_pkg::REG_HSCROLL1, vmrp_pkg::REG_HSCROLL2,
            vmrp_pkg::REG_HSCROLL3, vmrp_pkg::REG_HSCROLL4: begin
               if (scroll_first_ff[scroll_sel]) begin
                  scroll_low_in[scroll_sel] = req_write_data;
               end else begin
                  hscroll_in[scroll_sel] = {req_write_data[0], scroll_low_ff[scroll_sel]};
               end
               scroll_first_in[scroll_sel] = ~scroll_first_ff[scroll_sel];
            end
            vmrp_pkg::REG_VSCROLL1, vmrp_pkg::REG_VSCROLL2,
            vmrp_pkg::REG_VSCROLL3, vmrp_pkg::REG_VSCROLL4: begin
               vscroll_in[scroll_sel] = req_write_data;
            end
            vmrp_pkg::REG_VRAM_INC:     increment_mode_in = req_write_data;
            vmrp_pkg::REG_VRAM_ADDR_LO: video_address_in = {video_address_ff[15:8], req_write_data};
            vmrp_pkg::REG_VRAM_ADDR_HI: video_address_in = {req_write_data, video_address_ff[7:0]};
            vmrp_pkg::REG_VRAM_DATA_LO, vmrp_pkg::REG_VRAM_DATA_HI: begin
               vid_wr           = 1'b1;
               video_address_in = video_address_ff + vid_inc;
            end
            vmrp_pkg::REG_CG_ADDR: palette_address_in = {1'b0, req_write_data};
            vmrp_pkg::REG_CG_DATA: begin
               pal_wr             = 1'b1;
               palette_address_in = palette_address_ff + 9'd1;
            end
            vmrp_pkg::REG_MAIN_SCREEN: layer_in[10] = req_write_data;
            default: ;
         endcase
      end else if (accept) begin
         case (req_reg_index)
            vmrp_pkg::REG_OAM_READ: begin
               obj_rd        = 1'b1;
               stage_in.kind = vmrp_pkg::RD_OBJECT;
            end
            vmrp_pkg::REG_VRAM_READ_LO, vmrp_pkg::REG_VRAM_READ_HI: begin
               vid_rd           = 1'b1;
               video_address_in = video_address_ff + vid_inc;
               stage_in.kind    = (req_reg_index == vmrp_pkg::REG_VRAM_READ_LO) ?
                                  vmrp_pkg::RD_VIDEO_LO : vmrp_pkg::RD_VIDEO_HI;
            end
            vmrp_pkg::REG_CG_READ: begin
               pal_rd             = 1'b1;
               palette_address_in = palette_address_ff + 9'd1;
               stage_in.kind      = vmrp_pkg::RD_PALETTE;
            end
            vmrp_pkg::REG_STATUS0, vmrp_pkg::REG_STATUS1,
            vmrp_pkg::REG_STATUS2, vmrp_pkg::REG_STATUS3: begin
               stage_in.kind = vmrp_pkg::RD_STATUS;
            end
            default: ;
         endcase
      end
   end

   // clearing sweep: zero every entry, one address a cycle
   always_comb begin
      clear_busy_in  = clear_busy_ff;
      clear_count_in = clear_count_ff;
      if (clear_busy_ff) begin
         clear_count_in = clear_count_ff + CW'(1);
         if (clear_count_ff == CW'(VIDEO_BYTES - 1)) begin
            clear_busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (clear_busy_ff) begin
         vid_we = 1'b1;
         pal_we = (clear_count_ff < CW'(PALETTE_BYTES));
         obj_we = (clear_count_ff < CW'(OBJECT_BYTES));
         vid_wa = clear_count_ff[VA-1:0];
         pal_wa = clear_count_ff[PA-1:0];
         obj_wa = clear_count_ff[OA-1:0];
         wdata  = 8'd0;
      end else begin
         vid_we = vid_wr;
         pal_we = pal_wr;
         obj_we = obj_wr;
         vid_wa = vid_idx0;
         pal_wa = pal_idx;
         obj_wa = obj_idx;
         wdata  = req_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         video_address_ff    <= '0;
         increment_mode_ff   <= '0;
         palette_address_ff  <= '0;
         object_address_ff   <= '0;
         object_low_phase_ff <= 1'b1;
         object_rotation_ff  <= '0;
         for (int i = 0; i < vmrp_pkg::SCROLL_COUNT; i++) begin
            hscroll_ff[i]      <= '0;
            scroll_low_ff[i]   <= '0;
            scroll_first_ff[i] <= 1'b1;
            vscroll_ff[i]      <= '0;
         end
         for (int i = 0; i < vmrp_pkg::LAYER_COUNT; i++) begin
            layer_ff[i] <= '0;
         end
         clear_busy_ff  <= 1'b1;
         clear_count_ff <= '0;
      end else begin
         video_address_ff    <= video_address_in;
         increment_mode_ff   <= increment_mode_in;
         palette_address_ff  <= palette_address_in;
         object_address_ff   <= object_address_in;
         object_low_phase_ff <= object_low_phase_in;
         object_rotation_ff  <= object_rotation_in;
         hscroll_ff          <= hscroll_in;
         scroll_low_ff       <= scroll_low_in;
         scroll_first_ff     <= scroll_first_in;
         vscroll_ff          <= vscroll_in;
         layer_ff            <= layer_in;
         clear_busy_ff       <= clear_busy_in;
         clear_count_ff      <= clear_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   assign clear_busy = clear_busy_ff;
   assign stage      = stage_ff;

   // two copies of video memory give the two reads of a prefetch reload
   vmrp_ram #(.WIDTH(8), .DEPTH(VIDEO_BYTES)) u_video_lo (
      .clock   (clock),
      .wr_en   (vid_we),
      .wr_addr (vid_wa),
      .wr_data (wdata),
      .rd_en   (vid_rd),
      .rd_addr (vid_idx0),
      .rd_data (video_rd_lo)
   );

   vmrp_ram #(.WIDTH(8), .DEPTH(VIDEO_BYTES)) u_video_hi (
      .clock   (clock),
      .wr_en   (vid_we),
      .wr_addr (vid_wa),
      .wr_data (wdata),
      .rd_en   (vid_rd),
      .rd_addr (vid_idx1),
      .rd_data (video_rd_hi)
   );

   vmrp_ram #(.WIDTH(8), .DEPTH(PALETTE_BYTES)) u_palette (
      .clock   (clock),
      .wr_en   (pal_we),
      .wr_addr (pal_wa),
      .wr_data (wdata),
      .rd_en   (pal_rd),
      .rd_addr (pal_idx),
      .rd_data (palette_rd)
   );

   vmrp_ram #(.WIDTH(8), .DEPTH(OBJECT_BYTES)) u_object (
      .clock   (clock),
      .wr_en   (obj_we),
      .wr_addr (obj_wa),
      .wr_data (wdata),
      .rd_en   (obj_rd),
      .rd_addr (obj_idx),
      .rd_data (object_rd)
   );

`ifndef ASSERT_OFF
   // an address-low write always returns the object toggle to the low phase
   a_oam_addr_phase: assert property (@(posedge clock) disable iff (reset)
      accept && req_operation == vmrp_pkg::OP_WRITE &&
      req_reg_index == vmrp_pkg::REG_OAM_ADDR_LO |=> object_low_phase_ff)
      else $error("object phase not reset by address write");

   // a video data write steps the address by the programmed increment
   a_vid_step: assert property (@(posedge clock) disable iff (reset)
      accept && req_operation == vmrp_pkg::OP_WRITE &&
      (req_reg_index == vmrp_pkg::REG_VRAM_DATA_LO ||
       req_reg_index == vmrp_pkg::REG_VRAM_DATA_HI)
      |=> video_address_ff == $past(video_address_ff) + $past(vid_inc))
      else $error("video address step wrong");

   // no item is taken while the sweep owns the memory ports
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy_ff |-> !accept)
      else $error("item accepted during clearing sweep");
`endif

endmodule

@@ src/vmrp_resp.sv @@
// Response stage: prefetch buffers, read data select and the output register.
// Uses vmrp_pkg.
module vmrp_resp (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  vmrp_pkg::stage_type stage,
   input  logic [7:0]          video_rd_lo,
   input  logic [7:0]          video_rd_hi,
   input  logic [7:0]          palette_rd,
   input  logic [7:0]          object_rd,
   input  logic                rsp_stall,
   output vmrp_pkg::flow_type  flow,
   output logic                rsp_valid,
   output logic [7:0]          rsp_read_data
);

   logic        s1_valid_ff, s1_valid_in;
   logic [15:0] video_prefetch_ff, video_prefetch_in;
   logic [7:0]  palette_prefetch_ff, palette_prefetch_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_read_data_ff, rsp_read_data_in;
   logic        s1_advance;
   logic [7:0]  result;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      case (stage.kind)
         vmrp_pkg::RD_OBJECT:   result = object_rd;
         vmrp_pkg::RD_VIDEO_LO: result = video_prefetch_ff[7:0];
         vmrp_pkg::RD_VIDEO_HI: result = video_prefetch_ff[15:8];
         vmrp_pkg::RD_PALETTE:  result = palette_prefetch_ff;
         vmrp_pkg::RD_STATUS:   result = {stage.vblank, stage.hblank, 6'd0};
         default:               result = 8'd0;
      endcase
   end

   always_comb begin
      s1_valid_in         = accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
      video_prefetch_in   = video_prefetch_ff;
      palette_prefetch_in = palette_prefetch_ff;
      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      rsp_read_data_in    = rsp_read_data_ff;
      if (s1_advance) begin
         rsp_valid_in     = 1'b1;
         rsp_read_data_in = result;
         if (stage.kind == vmrp_pkg::RD_VIDEO_LO || stage.kind == vmrp_pkg::RD_VIDEO_HI) begin
            video_prefetch_in = {video_rd_hi, video_rd_lo};
         end
         if (stage.kind == vmrp_pkg::RD_PALETTE) begin
            palette_prefetch_in = palette_rd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff         <= 1'b0;
         video_prefetch_ff   <= '0;
         palette_prefetch_ff <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         s1_valid_ff         <= s1_valid_in;
         video_prefetch_ff   <= video_prefetch_in;
         palette_prefetch_ff <= palette_prefetch_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_read_data_ff <= rsp_read_data_in;
   end

   assign flow.s1_valid   = s1_valid_ff;
   assign flow.s1_advance = s1_advance;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_read_data_ff;

`ifndef ASSERT_OFF
   // an item leaving the stage always lands in the output register
   a_adv_lands: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid_ff)
      else $error("advanced item not presented");

   // items with no read behavior return zero
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      s1_advance && stage.kind == vmrp_pkg::RD_NONE |=> rsp_read_data_ff == 8'd0)
      else $error("nonzero data for item without read behavior");
`endif

endmodule

@@ src/video_memory_register_port_core.sv @@
// Top level of the video memory register port.
// Uses vmrp_pkg, vmrp_ctrl (decode, state, memories) and vmrp_resp (output side).
//  - req_* carries one CPU bus access to the 64-offset register window:
//    req_operation (0 read, 1 write), req_reg_index, req_write_data and the
//    vblank/hblank flags sampled for status reads. An item is taken at a
//    clock edge where req_valid is high and req_stall is low.
//  - rsp_* returns exactly one byte per item, in order: read data on reads,
//    zero on writes and on offsets with no read behavior. The receiver
//    holds rsp_stall high to keep the current item on rsp_read_data.
//  - Path: an accepted item is registered in the memory read and item
//    record registers, then loads into the output register and shows on
//    rsp_valid, unless a full output register held by rsp_stall blocks it.
//  - Throughput: one item per cycle with no bubble while rsp_stall is low;
//    a read right after a write to the same address sees the new byte.
//  - Stall: with rsp_stall high the output register holds, the item behind
//    it holds in the memory read stage, and req_stall rises once both are
//    full; nothing is dropped.
//  - Reset: synchronous, active high. Afterwards a clearing sweep zeroes the
//    video, palette and object memories, one address per cycle, across all
//    VIDEO_BYTES addresses (65536 by default); req_stall is high throughout.
module video_memory_register_port_core #(
   parameter int VIDEO_BYTES   = vmrp_pkg::VIDEO_BYTES_DEF,
   parameter int PALETTE_BYTES = vmrp_pkg::PALETTE_BYTES_DEF,
   parameter int OBJECT_BYTES  = vmrp_pkg::OBJECT_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_operation,
   input  logic [5:0] req_reg_index,
   input  logic [7:0] req_write_data,
   input  logic       req_vblank_in,
   input  logic       req_hblank_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data
);

   logic                clear_busy;
   logic                accept;
   vmrp_pkg::stage_type stage;
   vmrp_pkg::flow_type  flow;
   logic [7:0]          video_rd_lo;
   logic [7:0]          video_rd_hi;
   logic [7:0]          palette_rd;
   logic [7:0]          object_rd;

   // Stall while clearing, or while the read stage holds an item that
   // cannot move on into the output register.
   assign req_stall = clear_busy || (flow.s1_valid && !flow.s1_advance);
   assign accept    = req_valid && !req_stall;

   vmrp_ctrl #(
      .VIDEO_BYTES   (VIDEO_BYTES),
      .PALETTE_BYTES (PALETTE_BYTES),
      .OBJECT_BYTES  (OBJECT_BYTES)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_operation  (req_operation),
      .req_reg_index  (req_reg_index),
      .req_write_data (req_write_data),
      .req_vblank_in  (req_vblank_in),
      .req_hblank_in  (req_hblank_in),
      .clear_busy     (clear_busy),
      .stage          (stage),
      .video_rd_lo    (video_rd_lo),
      .video_rd_hi    (video_rd_hi),
      .palette_rd     (palette_rd),
      .object_rd      (object_rd)
   );

   vmrp_resp u_resp (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .stage         (stage),
      .video_rd_lo   (video_rd_lo),
      .video_rd_hi   (video_rd_hi),
      .palette_rd    (palette_rd),
      .object_rd     (object_rd),
      .rsp_stall     (rsp_stall),
      .flow          (flow),
      .rsp_valid     (rsp_valid),
      .rsp_read_data (rsp_read_data)
   );

`ifndef ASSERT_OFF
   // the read stage never drops an item: while full and blocked it stalls input
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      flow.s1_valid && !flow.s1_advance |=> flow.s1_valid)
      else $error("read stage lost an item");
`endif

endmodule

@@ tb/tb_top.sv @@
// Testbench for video_memory_register_port_core: directed and random bus accesses,
// checked against a predictor of the register window kept in this file.
// Depends on vmrp_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb_top;

   // Generous run limit. Covers the clearing sweep after reset, the items,
   // all idling on both sides and the forced receiver hold-off, several times over.
   localparam int LIMIT_CYCLES = 600000;
   localparam int IDLE_PCT     = 38;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_operation = vmrp_pkg::OP_READ;
   logic [5:0] req_reg_index = 6'h00;
   logic [7:0] req_write_data = 8'h00;
   logic       req_vblank_in = 1'b0;
   logic       req_hblank_in = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_read_data;

   video_memory_register_port_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_reg_index  (req_reg_index),
      .req_write_data (req_write_data),
      .req_vblank_in  (req_vblank_in),
      .req_hblank_in  (req_hblank_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data)
   );

   initial begin : clock_gen
      forever #2 clock = ~clock;
   end

   // Shared between the sender, the result checker and the test tasks.
   logic [7:0] read_data_due[$];   // expected bytes, oldest first
   int         items_sent = 0;
   int         mismatches = 0;
   logic       idle_on = 1'b1;     // random idling on both sides
   int         hold_request = 0;   // cycles of forced receiver hold-off

   // ------------------------------------------------------------------
   // Predictor state. Layer settings, scroll latches and rotation flags
   // are write-only, so they can never show up on rsp_read_data and are
   // not tracked here.
   // ------------------------------------------------------------------
   logic [7:0]  vid_mem [vmrp_pkg::VIDEO_BYTES_DEF]   = '{default: 8'h00};
   logic [7:0]  pal_mem [vmrp_pkg::PALETTE_BYTES_DEF] = '{default: 8'h00};
   logic [7:0]  obj_mem [vmrp_pkg::OBJECT_BYTES_DEF]  = '{default: 8'h00};
   logic [15:0] vid_addr = 16'h0000;
   logic [15:0] vid_buf  = 16'h0000;
   logic [7:0]  vid_inc  = 8'h00;
   logic [8:0]  pal_addr = 9'h000;
   logic [7:0]  pal_buf  = 8'h00;
   logic [8:0]  obj_addr = 9'h000;
   logic        obj_low  = 1'b1;

   // Object byte selected by the address and the low/high phase; the odd
   // byte past the end of the table wraps to entry zero.
   function automatic int obj_slot(input logic upper);
      int i;
      i = int'(obj_addr) % vmrp_pkg::OBJECT_BYTES_DEF;
      if (upper) begin
         i = i + 1;
         if (i >= vmrp_pkg::OBJECT_BYTES_DEF) i = 0;
      end
      return i;
   endfunction

   // Applies one accepted access to the predictor state and returns the byte
   // the block must answer with.
   function automatic logic [7:0] predict_read_data(input logic op, input logic [5:0] idx,
                                                    input logic [7:0] data,
                                                    input logic vb, input logic hb);
      logic [7:0]  rd;
      logic [15:0] step;
      logic [15:0] next_addr;
      rd = 8'h00;
      // video step: 1, or a power of two when the mode's top bit is set
      step = vid_inc[7] ? (16'd1 << vid_inc[6:4]) : 16'd1;
      next_addr = vid_addr + 16'd1;
      if (op == vmrp_pkg::OP_WRITE) begin
         case (idx)
            vmrp_pkg::REG_OAM_ADDR_LO: begin
               obj_addr = {obj_addr[8], data};
               obj_low  = 1'b1;
            end
            vmrp_pkg::REG_OAM_ADDR_HI: begin
               obj_addr = {data[0], obj_addr[7:0]};
               obj_low  = 1'b1;
            end
            vmrp_pkg::REG_OAM_DATA: begin
               if (obj_low) begin
                  obj_mem[obj_slot(1'b0)] = data;
               end else begin
                  obj_mem[obj_slot(1'b1)] = data;
                  obj_addr = obj_addr + 9'd2;
               end
               obj_low = ~obj_low;
            end
            vmrp_pkg::REG_VRAM_INC:     vid_inc = data;
            vmrp_pkg::REG_VRAM_ADDR_LO: vid_addr[7:0] = data;
            vmrp_pkg::REG_VRAM_ADDR_HI: vid_addr[15:8] = data;
            vmrp_pkg::REG_VRAM_DATA_LO, vmrp_pkg::REG_VRAM_DATA_HI: begin
               vid_mem[vid_addr] = data;
               vid_addr = vid_addr + step;
            end
            vmrp_pkg::REG_CG_ADDR: pal_addr = {1'b0, data};
            vmrp_pkg::REG_CG_DATA: begin
               pal_mem[pal_addr] = data;
               pal_addr = pal_addr + 9'd1;
            end
            default: ;
         endcase
      end else begin
         case (idx)
            vmrp_pkg::REG_OAM_READ: rd = obj_mem[obj_slot(~obj_low)];
            vmrp_pkg::REG_VRAM_READ_LO, vmrp_pkg::REG_VRAM_READ_HI: begin
               // return the buffered word, then refill it from the current address
               rd = (idx == vmrp_pkg::REG_VRAM_READ_LO) ? vid_buf[7:0] : vid_buf[15:8];
               vid_buf = {vid_mem[next_addr], vid_mem[vid_addr]};
               vid_addr = vid_addr + step;
            end
            vmrp_pkg::REG_CG_READ: begin
               rd = pal_buf;
               pal_buf = pal_mem[pal_addr];
               pal_addr = pal_addr + 9'd1;
            end
            vmrp_pkg::REG_STATUS0, vmrp_pkg::REG_STATUS1,
            vmrp_pkg::REG_STATUS2, vmrp_pkg::REG_STATUS3: rd = {vb, hb, 6'b000000};
            default: ;
         endcase
      end
      return rd;
   endfunction

   function automatic logic coin();
      return 1'($urandom_range(1));
   endfunction

   // ------------------------------------------------------------------
   // Sender: offers one item, idling first at random, and holds it until
   // the block takes it. The prediction is made at the accepting edge.
   // ------------------------------------------------------------------
   task automatic send_access(input logic op, input logic [5:0] idx, input logic [7:0] data,
                              input logic vb, input logic hb);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_reg_index  <= idx;
      req_write_data <= data;
      req_vblank_in  <= vb;
      req_hblank_in  <= hb;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      read_data_due.insert(read_data_due.size(), predict_read_data(op, idx, data, vb, hb));
      items_sent++;
   endtask

   // Sender pause: nothing offered until every expected item is back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (read_data_due.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Result side: checks each accepted item against the oldest expectation
   // and drives rsp_stall, either at random or for a forced hold-off that
   // is counted here.
   // ------------------------------------------------------------------
   initial begin : result_check
      int         hold_left;
      logic [7:0] want;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            if (read_data_due.size() == 0) begin
               $error("read_data: unexpected item, actual %02h", rsp_read_data);
               mismatches++;
            end else begin
               want = read_data_due.pop_front();
               if (rsp_read_data !== want) begin
                  $error("read_data: expected %02h, actual %02h", want, rsp_read_data);
                  mismatches++;
               end
            end
         end
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Object, video-low and palette reads right after reset, status reads with
   // one flag set at a time, and one offset with no read behavior.
   task automatic test_reset_state();
      send_access(vmrp_pkg::OP_READ, vmrp_pkg::REG_OAM_READ, 8'h00, 1'b0, 1'b0);
      send_access(vmrp_pkg::OP_READ, vmrp_pkg::REG_VRAM_READ_LO, 8'hFF, 1'b0, 1'b0);
      send_access(vmrp_pkg::OP_READ, vmrp_pkg::REG_CG_READ, 8'h00, 1'b0, 1'b0);
      send_access(vmrp_pkg::OP_READ, vmrp_pkg::REG_STATUS0, 8'h00, 1'b1, 1'b0);
      send_access(vmrp_pkg::OP_READ, vmrp_pkg::REG_STATUS3, 8'hFF, 1'b0, 1'b1);
      send_access(vmrp_pkg::OP_READ, vmrp_pkg::REG_DISPLAY, 8'h00, 1'b1, 1'b1);
   endtask

   // Video address wrap, the largest video step, prefetch latency on video
   // and palette reads, object phase handling at the top of the object address
   // range, and a write to a read-only offset.
   task automatic test_data_ports();
      // video: step 128, write at 0xFFFF, then read across the 16-bit wrap
      send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_VRAM_INC, 8'hF0, 1'b0, 1'b0);
      send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_VRAM_ADDR_LO, 8'hFF, 1'b0, 1'b0);
      send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_VRAM_ADDR_HI, 8'hFF, 1'b0, 1'b0);
      send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_VRAM_DATA_HI, 8'hA5, 1'b0, 1'b0);
      send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_VRAM_ADDR_LO, 8'hFF, 1'b0, 1'b0);
      send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_VRAM_ADDR_HI, 8'hFF, 1'b0, 1'b0);
      send_access(vmrp_pkg::OP_READ, vmrp_pkg::REG_VRAM_READ_LO, 8'h00, 1'b0, 1'b0);
      send_access(vmrp_pkg::OP_READ, vmrp_pkg::REG_VRAM_READ_LO, 8'h00, 1'b0, 1'b0);
      // palette: write at 0xFF, read it back through the read buffer
      send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_CG_ADDR, 8'hFF, 1'b0, 1'b0);
      send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_CG_DATA, 8'h81, 1'b0, 1'b0);
      send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_CG_ADDR, 8'hFF, 1'b0, 1'b0);
      send_access(vmrp_pkg::OP_READ, vmrp_pkg::REG_CG_READ, 8'h00, 1'b0, 1'b0);
      send_access(vmrp_pkg::OP_READ, vmrp_pkg::REG_CG_READ, 8'h00, 1'b0, 1'b0);
      // object: low/high pair at address 0x1FF
      send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_OAM_ADDR_HI, 8'h01, 1'b0, 1'b0);
      send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_OAM_ADDR_LO, 8'hFF, 1'b0, 1'b0);
      send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_OAM_DATA, 8'h11, 1'b0, 1'b0);
      send_access(vmrp_pkg::OP_READ, vmrp_pkg::REG_OAM_READ, 8'h00, 1'b0, 1'b0);
      send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_OAM_DATA, 8'h22, 1'b0, 1'b0);
      // writes to status offsets are ignored
      send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_STATUS3, 8'hFF, 1'b1, 1'b1);
   endtask

   // One short random sequence. Mostly well-formed set-address / burst /
   // read-back sequences on the three memories, plus stored-only settings, status reads and noise.
   task automatic random_sequence();
      int         kind;
      int         n;
      logic [7:0] lo;
      logic [7:0] hi;
      kind = $urandom_range(9);
      n    = $urandom_range(1, 8);
      case (kind)
         0, 1, 2: begin
            // video: keep most addresses low so read-back hits written bytes
            lo = 8'($urandom);
            hi = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1));
            send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_VRAM_INC, 8'($urandom),
                        coin(), coin());
            send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_VRAM_ADDR_LO, lo, coin(), coin());
            send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_VRAM_ADDR_HI, hi, coin(), coin());
            repeat (n) begin
               send_access(vmrp_pkg::OP_WRITE,
                           coin() ? vmrp_pkg::REG_VRAM_DATA_HI : vmrp_pkg::REG_VRAM_DATA_LO,
                           8'($urandom), coin(), coin());
            end
            send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_VRAM_ADDR_LO, lo, coin(), coin());
            send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_VRAM_ADDR_HI, hi, coin(), coin());
            repeat (n + 2) begin
               send_access(vmrp_pkg::OP_READ,
                           coin() ? vmrp_pkg::REG_VRAM_READ_HI : vmrp_pkg::REG_VRAM_READ_LO,
                           8'($urandom), coin(), coin());
            end
         end
         3, 4: begin
            // palette: start near 0xFF often so bursts cross into the upper half
            lo = coin() ? (8'hF8 | 8'($urandom_range(7))) : 8'($urandom);
            send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_CG_ADDR, lo, coin(), coin());
            repeat (n) begin
               send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_CG_DATA, 8'($urandom),
                           coin(), coin());
            end
            send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_CG_ADDR, lo, coin(), coin());
            repeat (n + 1) begin
               send_access(vmrp_pkg::OP_READ, vmrp_pkg::REG_CG_READ, 8'($urandom),
                           coin(), coin());
            end
         end
         5, 6: begin
            // object: fill pairs, rewind, then mix reads with overwrites
            lo = 8'($urandom);
            hi = {7'($urandom), coin()};
            send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_OAM_ADDR_HI, hi, coin(), coin());
            send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_OAM_ADDR_LO, lo, coin(), coin());
            repeat (2 * n) begin
               send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_OAM_DATA, 8'($urandom),
                           coin(), coin());
            end
            send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_OAM_ADDR_LO, lo, coin(), coin());
            repeat (2 * n) begin
               if (coin()) begin
                  send_access(vmrp_pkg::OP_READ, vmrp_pkg::REG_OAM_READ, 8'($urandom),
                              coin(), coin());
               end else begin
                  send_access(vmrp_pkg::OP_WRITE, vmrp_pkg::REG_OAM_DATA, 8'($urandom),
                              coin(), coin());
               end
            end
         end
         7: begin
            // stored-only settings and status reads
            repeat (n) begin
               if (coin()) begin
                  send_access(vmrp_pkg::OP_WRITE,
                              6'($urandom_range(vmrp_pkg::REG_BG_MODE,
                                                vmrp_pkg::REG_VSCROLL4)),
                              8'($urandom), coin(), coin());
               end else begin
                  send_access(vmrp_pkg::OP_READ,
                              6'($urandom_range(vmrp_pkg::REG_STATUS0,
                                                vmrp_pkg::REG_STATUS3)),
                              8'($urandom), coin(), coin());
               end
            end
         end
         default: begin
            // noise: any offset, either direction; also breaks object pairs
            repeat (n) begin
               send_access(coin(), 6'($urandom), 8'($urandom), coin(), coin());
            end
         end
      endcase
   endtask

   task automatic test_random_traffic(input int count);
      int target;
      target = items_sent + count;
      while (items_sent < target) random_sequence();
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering,
   // so the pipeline fills and req_stall must rise.
   task automatic test_receiver_holdoff();
      idle_on = 1'b0;
      hold_request = 150;
      test_random_traffic(40);
      idle_on = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // the first item waits out the memory clearing sweep behind req_stall
      test_reset_state();
      test_data_ports();
      test_receiver_holdoff();
      drain_results();
      test_random_traffic(600);
      drain_results();
      // stretch with no idling on either side
      idle_on = 1'b0;
      test_random_traffic(400);
      idle_on = 1'b1;
      test_random_traffic(600);
      drain_results();
      // wait past the two-stage pipeline to catch stray items
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("[video_memory_register_port_core] OK");
      end else begin
         $display("[video_memory_register_port_core] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("[video_memory_register_port_core] ERROR");
      $finish;
   end

endmodule
